// ----- rtl/core/ksa_pkg.sv -----
// Shared types and codes for the keyed slot allocator.
package ksa_pkg;

    localparam int KEY_W    = 64;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam status_t ST_NEW     = 3'd0;
    localparam status_t ST_HIT     = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_FREED   = 3'd3;
    localparam status_t ST_IGNORED = 3'd4;

endpackage

// ----- rtl/core/keyed_slot_allocator_lowest_free.sv -----
// Keyed slot allocator top level: input register, CAM lookup, result register.
// An accepted item waits in the input register until the result register can take it;
//   its result is then held in the result register until it is taken.
// Throughput: 1 item per cycle while m_ready holds; the parallel key compare over all slots
//   and the lowest-free priority encoder settle combinationally between the registers.
// Reset (aresetn low, synchronous): all slots free, both pipeline stages empty.
//   Key registers are not reset; they are written when a slot is taken.
module keyed_slot_allocator_lowest_free #(
    parameter int SLOTS = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  ksa_pkg::key_t       s_key,
    input  ksa_pkg::slot_t      s_slot_index,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output ksa_pkg::slot_t      m_granted_slot,
    output ksa_pkg::status_t    m_status
);
    import ksa_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------
    // Input register stage. An item sits here while the slot store is
    // looked up; it moves on when the result register can take it.
    // ------------------------------------------------------------------
    logic  in_valid_reg;
    logic  in_op_reg;
    key_t  in_key_reg;
    slot_t in_idx_reg;

    logic    out_valid_reg;
    slot_t   out_slot_reg;
    status_t out_status_reg;

    logic    advance;       // item in the input register completes this cycle
    slot_t   out_slot_next;
    status_t out_status_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg  <= s_operation;
            in_key_reg <= s_key;
            in_idx_reg <= s_slot_index;
        end
    end

    // ------------------------------------------------------------------
    // Slot store and lookup. State updates land on the same edge that
    // loads the result register, so the next item already sees them.
    // ------------------------------------------------------------------
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] in_use;
    logic [SLOTS-1:0] wr_vec;
    logic [SLOTS-1:0] clr_vec;
    logic [SLOTS-1:0] free_sel;     // decoded free index, empty if out of range

    logic             hit_any;
    logic [SLOTS-1:0] hit_onehot;
    logic [IDX_W-1:0] hit_idx;
    logic             free_any;
    logic [SLOTS-1:0] free_onehot;
    logic [IDX_W-1:0] free_idx;
    logic             free_valid;   // named slot exists and is in use

    ksa_slot_array #(
        .SLOTS (SLOTS)
    ) u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmp_key (in_key_reg),
        .wr_vec  (wr_vec),
        .wr_key  (in_key_reg),
        .clr_vec (clr_vec),
        .hit_vec (hit_vec),
        .in_use  (in_use)
    );

    // lowest matching slot (at most one ever matches)
    ksa_lowest #(
        .N (SLOTS)
    ) u_hit_enc (
        .vec    (hit_vec),
        .any    (hit_any),
        .onehot (hit_onehot),
        .idx    (hit_idx)
    );

    // lowest free slot
    ksa_lowest #(
        .N (SLOTS)
    ) u_free_enc (
        .vec    (~in_use),
        .any    (free_any),
        .onehot (free_onehot),
        .idx    (free_idx)
    );

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_sel[i] = (32'(in_idx_reg) == 32'(i));
        end
    end

    assign free_valid = |(free_sel & in_use);

    // Result decode and state update strobes
    always_comb begin
        logic [31:0] hit_idx32;
        logic [31:0] free_idx32;
        hit_idx32       = 32'(hit_idx);
        free_idx32      = 32'(free_idx);
        wr_vec          = '0;
        clr_vec         = '0;
        out_slot_next   = '0;
        out_status_next = ST_FULL;
        case (in_op_reg)
            OP_ALLOC: begin
                if (hit_any) begin
                    out_slot_next   = hit_idx32[SLOT_W-1:0];
                    out_status_next = ST_HIT;
                end else if (free_any) begin
                    out_slot_next   = free_idx32[SLOT_W-1:0];
                    out_status_next = ST_NEW;
                    wr_vec          = advance ? free_onehot : '0;
                end else begin
                    // full: slot reads as zero, nothing changes
                    out_slot_next   = '0;
                    out_status_next = ST_FULL;
                end
            end
            OP_FREE: begin
                out_slot_next = in_idx_reg;
                if (free_valid) begin
                    out_status_next = ST_FREED;
                    clr_vec         = advance ? free_sel : '0;
                end else begin
                    // double free or index past the last slot
                    out_status_next = ST_IGNORED;
                end
            end
            default: begin
                out_slot_next   = '0;
                out_status_next = ST_FULL;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_granted_slot = out_slot_reg;
    assign m_status       = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a held key lives in at most one slot
    a_unique_key: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hit_vec))
        else $error("key held by more than one slot");

    // a new allocation takes exactly one slot
    a_alloc_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_status_next == ST_NEW) |-> $onehot(wr_vec))
        else $error("allocation did not take exactly one slot");

    // full is only reported when every slot is in use
    a_full_true: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_status_next == ST_FULL) |-> (&in_use))
        else $error("full reported with a free slot");

    // input side stalls only when both stages hold an item
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a backed-up pipeline");

endmodule

// ----- rtl/core/ksa_lowest.sv -----
// Lowest-set-bit finder: one-hot isolate plus binary index.
module ksa_lowest #(
    parameter int N = 32
) (
    input  logic [N-1:0]                      vec,
    output logic                              any,
    output logic [N-1:0]                      onehot,
    output logic [((N > 1) ? $clog2(N) : 1)-1:0] idx
);
    localparam int IW = (N > 1) ? $clog2(N) : 1;

    // v & -v keeps only the lowest set bit
    assign onehot = vec & (~vec + N'(1));
    assign any    = |vec;

    always_comb begin
        idx = '0;
        for (int b = 0; b < IW; b++) begin
            for (int i = 0; i < N; i++) begin
                if (i[b]) begin
                    idx[b] = idx[b] | onehot[i];
                end
            end
        end
    end

endmodule

// ----- rtl/core/ksa_slot_array.sv -----
// Slot store: per-slot key registers, in-use flags and parallel key compare.
module ksa_slot_array #(
    parameter int SLOTS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ksa_pkg::key_t     cmp_key,
    input  logic [SLOTS-1:0]  wr_vec,
    input  ksa_pkg::key_t     wr_key,
    input  logic [SLOTS-1:0]  clr_vec,
    output logic [SLOTS-1:0]  hit_vec,
    output logic [SLOTS-1:0]  in_use
);
    import ksa_pkg::*;

    key_t             key_reg [SLOTS];
    logic [SLOTS-1:0] in_use_reg;
    logic [SLOTS-1:0] in_use_next;

    assign in_use_next = (in_use_reg | wr_vec) & ~clr_vec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_use_reg <= '0;
        end else begin
            in_use_reg <= in_use_next;
        end
    end

    // Keys carry no reset; a slot's key is only compared while it is in use.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (wr_vec[i]) begin
                key_reg[i] <= wr_key;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = in_use_reg[i] && (key_reg[i] == cmp_key);
        end
    end

    assign in_use = in_use_reg;

endmodule
